@@ hdl/ips_pkg.sv @@
// shared types and constants of the inter-frame psnr noise score block
`default_nettype none
package ips_pkg;

    localparam int PIX_W    = 8;
    localparam int RGB_W    = 3 * PIX_W;
    localparam int ACC_W    = 34;
    localparam int Q8_W     = 15;
    localparam int PIXOUT_W = 17;

    // log2 unit: operand width, exponent and fraction widths, mantissa in q30
    localparam int LOG_W    = 48;
    localparam int LOG_E_W  = 6;
    localparam int LOG_FRAC = 20;
    localparam int LOG_Q_W  = LOG_E_W + LOG_FRAC;
    localparam int MANT_W   = 31;

    // 3 * 255 * 255 peak energy per pixel
    localparam logic [17:0]        PEAK_X3         = 18'd195075;
    // 10*log10(2) in q24
    localparam logic [25:0]        TEN_LOG10_2_Q24 = 26'd50504453;
    // 99.9 * 256 * 10
    localparam logic [17:0]        SCORE_GAIN      = 18'd255744;
    localparam logic [Q8_W-1:0]    SCORE_FULL      = 15'd25600;
    localparam logic [Q8_W-1:0]    MIN_RESET       = 15'd6400;
    localparam logic [Q8_W-1:0]    MAX_RESET       = 15'd11520;
    localparam logic [Q8_W-1:0]    PSNR_SAT        = 15'h7FFF;
    localparam logic [ACC_W-1:0]   ACC_LIMIT       = {ACC_W{1'b1}};

    typedef enum logic {
        REG_MIN_CLAMP = 1'b0,
        REG_MAX_CLAMP = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             start;
        logic [LOG_W-1:0] operand;
    } log_req_t;

    typedef struct packed {
        logic               done;
        logic [LOG_Q_W-1:0] value;
    } log_rsp_t;

endpackage
`default_nettype wire

@@ hdl/ips_front.sv @@
// front end: frame store, squared difference and per-frame accumulation
`default_nettype none
module ips_front #(
    parameter int MAX_FRAME_PIXELS = 65536,
    parameter int CNT_W            = 17,
    parameter int ENT_W            = 53
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic [ips_pkg::RGB_W-1:0]   in_pixel,
    input  wire logic                        in_last,
    output logic                             q_push,
    output logic [ENT_W-1:0]                 q_data
);
    import ips_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_PIXELS);

    logic [RGB_W-1:0] store_mem [MAX_FRAME_PIXELS];

    logic [CNT_W-1:0] idx_reg, prev_len_reg;
    logic             ovf_reg;

    logic             v1_reg, last1_reg, cmp1_reg, compared1_reg, ovf1_reg;
    logic [RGB_W-1:0] pix1_reg, rd_reg;
    logic [CNT_W-1:0] count1_reg;
    logic [ACC_W-1:0] acc_reg;

    logic             accept, in_range, cmp_ok, ovf_now, compared_now;
    logic [CNT_W-1:0] count_now;

    // stage 0 classification
    assign accept       = in_valid && in_ready;
    assign in_range     = idx_reg < CNT_W'(MAX_FRAME_PIXELS);
    assign cmp_ok       = in_range && (idx_reg < prev_len_reg);
    assign count_now    = in_range ? idx_reg + 1'b1 : idx_reg;
    assign ovf_now      = ovf_reg || !in_range;
    assign compared_now = (prev_len_reg != '0) && (count_now == prev_len_reg) && !ovf_now;

    // frame store, read before write at the same position, read only where written
    always_ff @(posedge aclk) begin
        if (accept && cmp_ok) begin
            rd_reg <= store_mem[idx_reg[AW-1:0]];
        end
        if (accept && in_range) begin
            store_mem[idx_reg[AW-1:0]] <= in_pixel;
        end
    end

    // frame position and previous length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            prev_len_reg <= '0;
            ovf_reg      <= 1'b0;
        end else if (accept) begin
            if (in_last) begin
                idx_reg      <= '0;
                ovf_reg      <= 1'b0;
                prev_len_reg <= ovf_now ? '0 : count_now;
            end else begin
                idx_reg <= count_now;
                ovf_reg <= ovf_now;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg      <= in_pixel;
            last1_reg     <= in_last;
            cmp1_reg      <= cmp_ok;
            count1_reg    <= count_now;
            compared1_reg <= compared_now;
            ovf1_reg      <= ovf_now;
        end
    end

    // squared channel differences
    logic [PIX_W-1:0] ad_r, ad_g, ad_b;
    logic [15:0]      sq_r, sq_g, sq_b;
    logic [17:0]      sq_sum;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_sat;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        absdiff = (a >= b) ? a - b : b - a;
    endfunction

    always_comb begin
        ad_r    = absdiff(pix1_reg[2*PIX_W +: PIX_W], rd_reg[2*PIX_W +: PIX_W]);
        ad_g    = absdiff(pix1_reg[PIX_W +: PIX_W], rd_reg[PIX_W +: PIX_W]);
        ad_b    = absdiff(pix1_reg[0 +: PIX_W], rd_reg[0 +: PIX_W]);
        sq_r    = {8'd0, ad_r} * {8'd0, ad_r};
        sq_g    = {8'd0, ad_g} * {8'd0, ad_g};
        sq_b    = {8'd0, ad_b} * {8'd0, ad_b};
        sq_sum  = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
        acc_sum = {1'b0, acc_reg} + (ACC_W+1)'(cmp1_reg ? sq_sum : 18'd0);
        acc_sat = acc_sum[ACC_W] ? ACC_LIMIT : acc_sum[ACC_W-1:0];
    end

    // saturating accumulator and frame summary push
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= accept;
            if (v1_reg) begin
                acc_reg <= last1_reg ? '0 : acc_sat;
            end
        end
    end

    assign q_push = v1_reg && last1_reg;
    assign q_data = {count1_reg, acc_sat, compared1_reg, ovf1_reg};

endmodule
`default_nettype wire

@@ hdl/ips_fifo.sv @@
// short queue of frame summaries between front and back end
`default_nettype none
module ips_fifo #(
    parameter int WIDTH = 53,
    parameter int DEPTH = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic                            head_valid,
    output logic [WIDTH-1:0]                head_data,
    output logic [$clog2(DEPTH+1)-1:0]      level
);
    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] ent_reg [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [LW-1:0]    cnt_reg;

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign head_valid = cnt_reg != '0;
    assign head_data  = ent_reg[rd_reg];
    assign level      = cnt_reg;

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg < LW'(DEPTH)) || pop)
        else $error("frame summary pushed into a full queue");

endmodule
`default_nettype wire

@@ hdl/ips_log2.sv @@
// iterative log2 in q20: leading-one search then repeated squaring
`default_nettype none
module ips_log2 (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ips_pkg::log_req_t req,
    output ips_pkg::log_rsp_t      rsp
);
    import ips_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_FRAC} lstate_t;

    lstate_t             state_reg;
    logic [LOG_W-1:0]    x_reg;
    logic [LOG_E_W-1:0]  e_reg;
    logic [MANT_W-1:0]   m_reg;
    logic [LOG_FRAC-1:0] frac_reg;
    logic [4:0]          it_reg;
    log_rsp_t            rsp_reg;

    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;

    // one squaring step, mantissa back to q30
    always_comb begin
        sq = m_reg * m_reg;
        t  = sq[2*MANT_W-1:MANT_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= L_IDLE;
            rsp_reg.done <= 1'b0;
        end else begin
            rsp_reg.done <= (state_reg == L_FRAC) && (it_reg == 5'(LOG_FRAC-1));
            case (state_reg)
                L_IDLE: begin
                    if (req.start) begin
                        x_reg     <= (req.operand == '0) ? LOG_W'(1) : req.operand;
                        e_reg     <= LOG_E_W'(LOG_W-1);
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (x_reg[LOG_W-1]) begin
                        m_reg     <= x_reg[LOG_W-1 -: MANT_W];
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= L_FRAC;
                    end else begin
                        x_reg <= x_reg << 1;
                        e_reg <= e_reg - 1'b1;
                    end
                end
                L_FRAC: begin
                    frac_reg <= {frac_reg[LOG_FRAC-2:0], t[MANT_W]};
                    m_reg    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
                    it_reg   <= it_reg + 1'b1;
                    if (it_reg == 5'(LOG_FRAC-1)) begin
                        rsp_reg.value <= {e_reg, frac_reg[LOG_FRAC-2:0], t[MANT_W]};
                        state_reg     <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

@@ hdl/ips_back.sv @@
// back end: psnr, clamping, score division and result register
`default_nettype none
module ips_back #(
    parameter int CNT_W = 17,
    parameter int ENT_W = 53
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire logic [ENT_W-1:0]            q_data,
    output logic                             q_pop,
    input  wire logic [ips_pkg::Q8_W-1:0]    min_clamp,
    input  wire logic [ips_pkg::Q8_W-1:0]    max_clamp,
    output ips_pkg::log_req_t                log_req,
    input  wire ips_pkg::log_rsp_t           log_rsp,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ips_pkg::Q8_W-1:0]         m_score,
    output logic [ips_pkg::Q8_W-1:0]         m_psnr,
    output logic [ips_pkg::ACC_W-1:0]        m_sum,
    output logic [ips_pkg::PIXOUT_W-1:0]     m_pixels,
    output logic                             m_compared,
    output logic                             m_overflow
);
    import ips_pkg::*;

    localparam int NUM_W = CNT_W + 18;
    localparam int DVD_W = 35;
    localparam int DVS_W = 20;
    localparam int PRD_W = 2 * LOG_Q_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SEL, S_LOGA, S_WAITA, S_LOGB, S_WAITB, S_DMUL, S_VRND,
        S_CLAMP, S_SPAN, S_DINIT, S_DIV, S_SCORE, S_DONE
    } bstate_t;

    bstate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               cmp_reg, ovf_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [LOG_Q_W-1:0] la_reg, lb_reg;
    logic [PRD_W-1:0]   prod_reg;
    logic [Q8_W-1:0]    psnr_reg, score_reg;
    logic [18:0]        span_reg;
    logic [32:0]        a_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVS_W-1:0]   dvs_reg, rem_reg;
    logic [5:0]         bit_reg;
    log_req_t           req_reg;

    logic               m_valid_reg, m_cmp_reg, m_ovf_reg;
    logic [Q8_W-1:0]    m_score_reg, m_psnr_reg;
    logic [ACC_W-1:0]   m_sum_reg;
    logic [PIXOUT_W-1:0] m_pix_reg;

    logic               load_out;
    logic [LOG_Q_W-1:0] d_diff;
    logic [PRD_W:0]     rnd;
    logic [16:0]        v_q8;
    logic [Q8_W-1:0]    p_lo, p_clamp;
    logic [DVS_W:0]     rem_sh, rem_sub;
    logic               ge;

    always_comb begin
        q_pop    = (state_reg == S_IDLE) && q_valid;
        load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
        d_diff   = (la_reg > lb_reg) ? la_reg - lb_reg : '0;
        rnd      = {1'b0, prod_reg} + ((PRD_W+1)'(1) << 35);
        v_q8     = rnd[PRD_W:36];
        // raise to min first, then lower to max
        p_lo     = (psnr_reg < min_clamp) ? min_clamp : psnr_reg;
        p_clamp  = (p_lo > max_clamp) ? max_clamp : p_lo;
        // restoring division step
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        ge       = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            req_reg.start <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            req_reg.start <= (state_reg == S_LOGA) || (state_reg == S_LOGB);
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        {cnt_reg, acc_reg, cmp_reg, ovf_reg} <= q_data;
                        state_reg <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (!cmp_reg) begin
                        psnr_reg  <= min_clamp;
                        state_reg <= S_CLAMP;
                    end else if (acc_reg <= ACC_W'(1)) begin
                        psnr_reg  <= max_clamp;
                        state_reg <= S_CLAMP;
                    end else begin
                        num_reg   <= cnt_reg * PEAK_X3;
                        state_reg <= S_LOGA;
                    end
                end
                S_LOGA: begin
                    req_reg.operand <= LOG_W'(num_reg);
                    state_reg       <= S_WAITA;
                end
                S_WAITA: begin
                    if (log_rsp.done) begin
                        la_reg    <= log_rsp.value;
                        state_reg <= S_LOGB;
                    end
                end
                S_LOGB: begin
                    req_reg.operand <= LOG_W'(acc_reg);
                    state_reg       <= S_WAITB;
                end
                S_WAITB: begin
                    if (log_rsp.done) begin
                        lb_reg    <= log_rsp.value;
                        state_reg <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    prod_reg  <= d_diff * TEN_LOG10_2_Q24;
                    state_reg <= S_VRND;
                end
                S_VRND: begin
                    psnr_reg  <= (v_q8 > 17'(PSNR_SAT)) ? PSNR_SAT : v_q8[Q8_W-1:0];
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    psnr_reg  <= p_clamp;
                    state_reg <= S_SPAN;
                end
                S_SPAN: begin
                    if (max_clamp <= min_clamp) begin
                        score_reg <= SCORE_FULL;
                        state_reg <= S_DONE;
                    end else begin
                        span_reg  <= {4'd0, max_clamp - min_clamp} * 19'd10;
                        a_reg     <= (psnr_reg - min_clamp) * SCORE_GAIN;
                        state_reg <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    dvd_reg   <= {1'b0, a_reg, 1'b0} + DVD_W'(span_reg);
                    dvs_reg   <= {span_reg, 1'b0};
                    rem_reg   <= '0;
                    bit_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 6'(DVD_W-1)) state_reg <= S_SCORE;
                end
                S_SCORE: begin
                    score_reg <= (dvd_reg >= DVD_W'(SCORE_FULL)) ? '0
                                 : SCORE_FULL - dvd_reg[Q8_W-1:0];
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        m_score_reg <= score_reg;
                        m_psnr_reg  <= psnr_reg;
                        m_sum_reg   <= acc_reg;
                        m_pix_reg   <= PIXOUT_W'(cnt_reg);
                        m_cmp_reg   <= cmp_reg;
                        m_ovf_reg   <= ovf_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign log_req    = req_reg;
    assign m_valid    = m_valid_reg;
    assign m_score    = m_score_reg;
    assign m_psnr     = m_psnr_reg;
    assign m_sum      = m_sum_reg;
    assign m_pixels   = m_pix_reg;
    assign m_compared = m_cmp_reg;
    assign m_overflow = m_ovf_reg;

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("summary popped from an empty queue");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (dvs_reg != '0))
        else $error("score division by zero span");

    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (score_reg <= SCORE_FULL))
        else $error("score above full scale");

endmodule
`default_nettype wire

@@ hdl/interframe_psnr_noise_score.sv @@
// top level of the inter-frame psnr noise score block
//
// Input stream s_*: one rgb pixel per item, s_tlast on the last pixel of a
// frame. Pixels are taken at one per clock while s_tready is high; each is
// compared with the pixel at the same position of the previous frame held in
// an on-chip frame store, where that frame and the store reach the position.
// Output stream m_*: one item per frame with the score, clamped psnr, error
// sum and pixel count in m_tdata, and the compared and overflow flags in
// m_tuser. The result follows the last pixel through the leading-one search
// (one bit per step), 20 squaring steps of the shared log2 unit (run twice)
// and the 35-step score divider. Frame summaries wait in a four-entry queue,
// so a receiver that stalls m_tready holds the result register and, once the
// queue holds three summaries, s_tready drops. A synchronous low aresetn
// clears all control state and sets the clamps to 25 dB and 45 dB; the frame
// store needs no clearing since the first frame after reset is never compared.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 min clamp,
// 1 max clamp); the user writes only while the block is idle (not enforced).
`default_nettype none
module interframe_psnr_noise_score #(
    parameter int MAX_FRAME_PIXELS = 65536
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
    input  wire logic [23:0]  s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // noise_score[14:0], clamped_psnr_db[29:15], squared_error_sum[63:30],
    // frame_pixels[80:64], zero fill [87:81]
    output logic [87:0]       m_tdata,
    // frame_compared[0], store_overflow[1]
    output logic [1:0]        m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [14:0]  cfg_data
);
    import ips_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int ENT_W  = CNT_W + ACC_W + 2;
    localparam int QDEPTH = 4;
    localparam int LVL_W  = $clog2(QDEPTH + 1);

    logic [Q8_W-1:0]    min_reg, max_reg;
    logic               q_push, q_pop, q_valid;
    logic [ENT_W-1:0]   q_wdata, q_rdata;
    logic [LVL_W-1:0]   q_level;
    log_req_t           log_req;
    log_rsp_t           log_rsp;
    logic [Q8_W-1:0]    o_score, o_psnr;
    logic [ACC_W-1:0]   o_sum;
    logic [PIXOUT_W-1:0] o_pix;
    logic               o_cmp, o_ovf;

    // clamp registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_MIN_CLAMP: min_reg <= cfg_data;
                REG_MAX_CLAMP: max_reg <= cfg_data;
                default:       min_reg <= min_reg;
            endcase
        end
    end

    // keep room for a summary in flight
    assign s_tready = q_level < LVL_W'(QDEPTH - 1);

    ips_front #(
        .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
        .CNT_W(CNT_W),
        .ENT_W(ENT_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_pixel({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
        .in_last(s_tlast),
        .q_push(q_push), .q_data(q_wdata)
    );

    ips_fifo #(.WIDTH(ENT_W), .DEPTH(QDEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_wdata),
        .pop(q_pop), .head_valid(q_valid), .head_data(q_rdata),
        .level(q_level)
    );

    ips_log2 u_log2 (
        .aclk(aclk), .aresetn(aresetn), .req(log_req), .rsp(log_rsp)
    );

    ips_back #(.CNT_W(CNT_W), .ENT_W(ENT_W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_data(q_rdata), .q_pop(q_pop),
        .min_clamp(min_reg), .max_clamp(max_reg),
        .log_req(log_req), .log_rsp(log_rsp),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_score(o_score), .m_psnr(o_psnr), .m_sum(o_sum), .m_pixels(o_pix),
        .m_compared(o_cmp), .m_overflow(o_ovf)
    );

    assign m_tdata = {7'd0, o_pix, o_sum, o_psnr, o_score};
    assign m_tuser = {o_ovf, o_cmp};

endmodule
`default_nettype wire
